/* rtl/core/lfu_cache_defines.svh */
// Assertion macros for the LFU cache checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LFU_CACHE_DEFINES_SVH
`define LFU_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfu_cache: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfu_cache: check failed");

`endif

/* rtl/core/lfu_pkg.sv */
// Shared types and constants of the LFU cache.
// No dependencies; imported by lfu_cache.
package lfu_pkg;

  localparam int unsigned CFG_W       = 5;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned ENTRIES_DEF = 16;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } lfu_state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] last_use;
  } lfu_row_t;

endpackage

/* rtl/core/lfu_cache.sv */
// Key-value cache with least-frequently-used replacement.
// Depends on lfu_pkg; entry rows sit in one synchronous row memory, valid bits in registers.
//
//  channel   | handshake               | fields
//  ----------+-------------------------+----------------------------------------
//  request   | start / busy            | req_type_i, lookup_key_i, put_value_i
//  result    | result_valid_o (strobe) | found_o, read_value_o
//  capacity  | cfg_we_i                | cfg_wdata_i
//
// A request keeps busy high through the SCAN, LAST and FINISH states: one row of the
// memory is read per cycle to find the key, the first free slot and the
// eviction victim, then FINISH writes the touched row back, if there is one.
// A get's result shows for one cycle right after busy drops; a put gives none.
// Reset clears the valid bits, occupancy and request clock; no clearing pass.
// The receiver cannot stall; the next request may start while the result shows.
module lfu_cache #(
  parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type_i,
  input  logic [lfu_pkg::KEY_W-1:0] lookup_key_i,
  input  logic [lfu_pkg::VAL_W-1:0] put_value_i,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                      result_valid_o,
  output logic                      found_o,
  output logic [lfu_pkg::VAL_W-1:0] read_value_o
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);

  lfu_state_e state_q, state_d;

  // Row memory.
  lfu_row_t mem_q [ENTRIES];
  lfu_row_t rd_data_q;
  lfu_row_t wr_row;
  logic [IDX_W-1:0] wr_idx;
  logic mem_we, mem_re;

  logic [ENTRIES-1:0] valid_q;
  logic [CFG_W-1:0] cap_q, cap_eff, occ_q;
  logic [TIME_W-1:0] clk_cnt_q;

  // Request latch.
  logic             req_put_q;
  logic [KEY_W-1:0] req_key_q;
  logic [VAL_W-1:0] req_val_q;

  // Scan pipeline.
  logic [IDX_W-1:0] rd_idx_q, cmp_idx_q;
  logic             cmp_vld_q;
  logic             accept;

  // Scan results.
  logic             hit_q, free_q, vic_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q, vic_idx_q;
  logic [VAL_W-1:0] hit_val_q;
  logic [CNT_W-1:0] hit_cnt_q, vic_cnt_q;
  logic [TIME_W-1:0] vic_lu_q;

  logic row_valid, key_match, better;
  logic [CNT_W-1:0] hit_cnt_inc;

  // Result registers.
  logic res_valid_q, res_valid_d;
  logic found_q, found_d;
  logic [VAL_W-1:0] rvalue_q, rvalue_d;
  logic occ_inc;

  assign accept  = start && (state_q == ST_IDLE);
  assign cap_eff = ({27'b0, cap_q} > ENTRIES_W) ? CFG_W'(ENTRIES) : cap_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start) state_d = ST_SCAN;
      ST_SCAN:   if (rd_idx_q == LAST_IDX) state_d = ST_LAST;
      ST_LAST:   state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign hit_cnt_inc = (hit_cnt_q != '1) ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;

  // Outputs of the sequencer: memory access, result and occupancy update.
  always_comb begin
    busy         = 1'b1;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    wr_idx       = hit_idx_q;
    wr_row.key      = req_key_q;
    wr_row.value    = req_val_q;
    wr_row.count    = CNT_W'(1);
    wr_row.last_use = clk_cnt_q;
    res_valid_d  = 1'b0;
    found_d      = 1'b0;
    rvalue_d     = '0;
    occ_inc      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        mem_re = 1'b1;
      end
      ST_LAST: begin
      end
      ST_FINISH: begin
        if (req_put_q == REQ_GET) begin
          res_valid_d = 1'b1;
          found_d     = hit_q;
          rvalue_d    = hit_q ? hit_val_q : '0;
          if (hit_q) begin
            mem_we       = 1'b1;
            wr_row.value = hit_val_q;
            wr_row.count = hit_cnt_inc;
          end
        end else if (cap_eff != '0) begin
          mem_we = 1'b1;
          if (hit_q) begin
            wr_row.count = hit_cnt_inc;
          end else if (occ_q < cap_eff && free_q) begin
            wr_idx  = free_idx_q;
            occ_inc = 1'b1;
          end else begin
            wr_idx = vic_q ? vic_idx_q : '0;
          end
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Row memory: one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wr_row;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  assign row_valid = valid_q[cmp_idx_q];
  assign key_match = row_valid && (rd_data_q.key == req_key_q);
  assign better    = row_valid && (!vic_q || (rd_data_q.count < vic_cnt_q) ||
                     (rd_data_q.count == vic_cnt_q && rd_data_q.last_use < vic_lu_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      clk_cnt_q   <= '0;
      rd_idx_q    <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
      req_put_q   <= REQ_GET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      cmp_vld_q   <= mem_re;
      cmp_idx_q   <= rd_idx_q;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        req_put_q <= req_type_i;
        rd_idx_q  <= '0;
        hit_q     <= 1'b0;
        free_q    <= 1'b0;
        vic_q     <= 1'b0;
        if (clk_cnt_q != '1) begin
          clk_cnt_q <= clk_cnt_q + TIME_W'(1);
        end
      end
      if (mem_re && rd_idx_q != LAST_IDX) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
      // Keep the first match and the first free slot; keep the least used victim.
      if (cmp_vld_q) begin
        if (key_match && !hit_q) hit_q <= 1'b1;
        if (!row_valid && !free_q) free_q <= 1'b1;
        if (better) vic_q <= 1'b1;
      end
      if (mem_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (occ_inc) begin
        occ_q <= occ_q + CFG_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_key_q <= lookup_key_i;
      req_val_q <= put_value_i;
    end
    if (cmp_vld_q) begin
      if (key_match && !hit_q) begin
        hit_idx_q <= cmp_idx_q;
        hit_val_q <= rd_data_q.value;
        hit_cnt_q <= rd_data_q.count;
      end
      if (!row_valid && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (better) begin
        vic_idx_q <= cmp_idx_q;
        vic_cnt_q <= rd_data_q.count;
        vic_lu_q  <= rd_data_q.last_use;
      end
    end
    found_q  <= found_d;
    rvalue_q <= rvalue_d;
  end

  assign result_valid_o = res_valid_q;
  assign found_o        = found_q;
  assign read_value_o   = rvalue_q;

endmodule

/* rtl/core/lfu_checker.sv */
// Port-level checks of the LFU cache, bound to lfu_cache.
// Depends on lfu_cache_defines.svh for the assertion macros.
`include "lfu_cache_defines.svh"

module lfu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic        found_o,
  input logic [31:0] read_value_o
);

  // A result shows only in the cycle right after a request finished.
  `LFU_ASSERT_IMP(a_result_after_busy, result_valid_o, $past(busy) && !busy)

  // An accepted transaction keeps the block busy in the next cycle.
  `LFU_ASSERT_NXT(a_accept_busy, start && !busy, busy)

  // A miss reports a zero value.
  `LFU_ASSERT_IMP(a_miss_zero, result_valid_o && !found_o, read_value_o == 32'd0)

  // No two results back to back: a request always passes through SCAN, LAST and FINISH.
  `LFU_ASSERT_NXT(a_single_strobe, result_valid_o, !result_valid_o)

endmodule

bind lfu_cache lfu_checker u_lfu_checker (.*);
